// File: src/nco_complex_mixer_core_defines.svh
// Assertion macros shared by the mixer checker.
// No dependencies; take in with a plain include.
`ifndef NCO_COMPLEX_MIXER_CORE_DEFINES_SVH
`define NCO_COMPLEX_MIXER_CORE_DEFINES_SVH

// same-cycle implication under active-low reset
`define NCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("nco_complex_mixer_core: assertion failed");

// next-cycle implication under active-low reset
`define NCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("nco_complex_mixer_core: assertion failed");

`endif

// File: src/ncomix_pkg.sv
// Shared constants, types and the quarter-wave sine table builder for the mixer.
// No dependencies.
package ncomix_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int PHASE_BITS    = 32;
  localparam int LUT_ADDR_BITS = 10;
  localparam int LUT_SIZE      = 1 << LUT_ADDR_BITS;
  localparam int MAG_BITS      = SAMPLE_BITS - 1;
  localparam int CFG_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [APB_ADDR_BITS-1:0] ADDR_PHASE_INC = APB_ADDR_BITS'(0);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  typedef logic [LUT_ADDR_BITS:0]        lut_idx_t;
  typedef logic [MAG_BITS-1:0]           mag_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic     rd_en;
    lut_idx_t idx_sin;
    lut_idx_t idx_cos;
  } lut_req_t;

  typedef struct packed {
    logic  bypass;
    quad_e quad;
  } mix_ctrl_t;

  typedef mag_t quarter_tab_t [LUT_SIZE+1];

  // unsigned quotient by shift and subtract, for table elaboration only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int              b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // entry k = A * sin(pi/2 * k / LUT_SIZE) by a Q30 Taylor series, rounded half up
  function automatic quarter_tab_t build_quarter_tab();
    quarter_tab_t      tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   div;
    longint            sum;
    longint            amp;
    longint            v;
    int                k;
    int                n;
    amp = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    for (k = 0; k <= LUT_SIZE; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >> LUT_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 8; n++) begin
        div  = longint'((2 * n) * (2 * n + 1));
        term = udiv64((term * x2) >> 30, div);
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (amp * sum + (longint'(1) <<< 29)) >>> 30;
      if (v > amp) begin
        v = amp;
      end
      tab[k] = MAG_BITS'(v);
    end
    return tab;
  endfunction

endpackage

// File: src/ncomix_if.sv
// Sample and result stream interfaces of the mixer, valid/ready handshake.
// Depends on ncomix_pkg.
interface ncomix_in_if;
  logic                 valid;
  logic                 ready;
  ncomix_pkg::sample_t  in_i;
  ncomix_pkg::sample_t  in_q;

  modport source (output valid, output in_i, output in_q, input ready);
  modport sink (input valid, input in_i, input in_q, output ready);
endinterface

interface ncomix_out_if;
  logic                 valid;
  logic                 ready;
  ncomix_pkg::sample_t  out_i;
  ncomix_pkg::sample_t  out_q;

  modport source (output valid, output out_i, output out_q, input ready);
  modport sink (input valid, input out_i, input out_q, output ready);
endinterface

// File: src/nco_complex_mixer_core.sv
// Top level of the NCO complex mixer; depends on ncomix_pkg, the stream
// interfaces, ncomix_phase, ncomix_lut and ncomix_rotate.
//
// Rotates each I/Q sample by the running NCO phase and advances the phase by
// the phase increment register (byte address 0, 32 bits, two's complement,
// turns scaled by 2^32). A zero increment passes samples through and holds the
// phase. One sample can be taken every clock while the input stage does not
// stall; each sample passes through the input register, loaded together with
// the registered sine ROM read, and then the result register. The result
// register stalls only when it is full and not taken; the input stage
// stalls only when it is also full.
module nco_complex_mixer_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  ncomix_in_if.sink                             sample_i,
  ncomix_out_if.source                          mixed_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ncomix_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [ncomix_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [ncomix_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                  pready
);
  import ncomix_pkg::*;

  logic      in_ready;
  logic      out_ready_int;
  logic      in_accept;
  logic      s1_valid_q;
  logic      out_valid_q;
  sample_t   s1_i_q;
  sample_t   s1_q_q;
  mix_ctrl_t s1_ctrl_q;
  sample_t   out_i_q;
  sample_t   out_q_q;
  lut_req_t  lut_req;
  mix_ctrl_t ctrl;
  mag_t      sin_mag;
  mag_t      cos_mag;
  sample_t   rot_i;
  sample_t   rot_q;

  assign pready        = 1'b1;
  assign out_ready_int = !out_valid_q || mixed_o.ready;
  assign in_ready      = !s1_valid_q || out_ready_int;
  assign in_accept     = sample_i.valid && in_ready;

  assign sample_i.ready = in_ready;
  assign mixed_o.valid  = out_valid_q;
  assign mixed_o.out_i  = out_i_q;
  assign mixed_o.out_q  = out_q_q;

  ncomix_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .advance_i (in_accept),
    .lut_req_o (lut_req),
    .ctrl_o    (ctrl)
  );

  ncomix_lut u_lut (
    .clk_i     (clk_i),
    .req_i     (lut_req),
    .sin_mag_o (sin_mag),
    .cos_mag_o (cos_mag)
  );

  ncomix_rotate u_rotate (
    .s_i_i     (s1_i_q),
    .s_q_i     (s1_q_q),
    .sin_mag_i (sin_mag),
    .cos_mag_i (cos_mag),
    .ctrl_i    (s1_ctrl_q),
    .r_i_o     (rot_i),
    .r_q_o     (rot_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (out_ready_int) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_i_q    <= sample_i.in_i;
      s1_q_q    <= sample_i.in_q;
      s1_ctrl_q <= ctrl;
    end
    if (out_ready_int && s1_valid_q) begin
      out_i_q <= rot_i;
      out_q_q <= rot_q;
    end
  end

endmodule

// File: src/ncomix_phase.sv
// Phase increment register, phase accumulator and table address generation.
// Depends on ncomix_pkg.
module ncomix_phase (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ncomix_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [ncomix_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [ncomix_pkg::CFG_DATA_BITS-1:0]  prdata,
  input  logic                                  advance_i,
  output ncomix_pkg::lut_req_t                  lut_req_o,
  output ncomix_pkg::mix_ctrl_t                 ctrl_o
);
  import ncomix_pkg::*;

  logic [CFG_DATA_BITS-1:0] inc_q;
  logic [CFG_DATA_BITS-1:0] inc_d;
  logic [PHASE_BITS-1:0]    phase_q;
  logic [PHASE_BITS-1:0]    phase_d;
  logic [PHASE_BITS-1:0]    inc_lo;
  logic [LUT_ADDR_BITS+1:0] addr;
  lut_idx_t                 n_idx;
  logic                     wr_en;

  assign inc_lo = inc_q[PHASE_BITS-1:0];
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_PHASE_INC);
  assign inc_d  = wr_en ? pwdata : inc_q;
  assign phase_d = advance_i ? (phase_q + inc_lo) : phase_q;
  assign prdata = (paddr == ADDR_PHASE_INC) ? inc_q : '0;

  assign addr  = phase_q[PHASE_BITS-1 -: (LUT_ADDR_BITS + 2)];
  assign n_idx = {1'b0, addr[LUT_ADDR_BITS-1:0]};

  assign lut_req_o.rd_en   = advance_i;
  assign lut_req_o.idx_sin = n_idx;
  assign lut_req_o.idx_cos = (LUT_ADDR_BITS + 1)'(LUT_SIZE) - n_idx;
  assign ctrl_o.bypass     = (inc_lo == '0);
  assign ctrl_o.quad       = quad_e'(addr[LUT_ADDR_BITS+1:LUT_ADDR_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q   <= '0;
      phase_q <= '0;
    end else begin
      inc_q   <= inc_d;
      phase_q <= phase_d;
    end
  end

endmodule

// File: src/ncomix_lut.sv
// Quarter-wave sine ROM with two registered read ports.
// Depends on ncomix_pkg.
module ncomix_lut (
  input  logic                  clk_i,
  input  ncomix_pkg::lut_req_t  req_i,
  output ncomix_pkg::mag_t      sin_mag_o,
  output ncomix_pkg::mag_t      cos_mag_o
);
  import ncomix_pkg::*;

  localparam quarter_tab_t QTAB = build_quarter_tab();

  mag_t sin_mag_q;
  mag_t cos_mag_q;

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      sin_mag_q <= QTAB[req_i.idx_sin];
      cos_mag_q <= QTAB[req_i.idx_cos];
    end
  end

  assign sin_mag_o = sin_mag_q;
  assign cos_mag_o = cos_mag_q;

endmodule

// File: src/ncomix_rotate.sv
// Complex rotation by the table sine and cosine, with rounding and saturation.
// Depends on ncomix_pkg.
module ncomix_rotate (
  input  ncomix_pkg::sample_t    s_i_i,
  input  ncomix_pkg::sample_t    s_q_i,
  input  ncomix_pkg::mag_t       sin_mag_i,
  input  ncomix_pkg::mag_t       cos_mag_i,
  input  ncomix_pkg::mix_ctrl_t  ctrl_i,
  output ncomix_pkg::sample_t    r_i_o,
  output ncomix_pkg::sample_t    r_q_o
);
  import ncomix_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) << (SAMPLE_BITS - 2);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  sample_t                  a_s;
  sample_t                  b_s;
  sample_t                  sin_v;
  sample_t                  cos_v;
  logic signed [PROD_W-1:0] p_ic;
  logic signed [PROD_W-1:0] p_qs;
  logic signed [PROD_W-1:0] p_is;
  logic signed [PROD_W-1:0] p_qc;
  logic signed [ACC_W-1:0]  acc_i;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  sh_i;
  logic signed [ACC_W-1:0]  sh_q;
  sample_t                  sat_i;
  sample_t                  sat_q;

  assign a_s = sample_t'({1'b0, sin_mag_i});
  assign b_s = sample_t'({1'b0, cos_mag_i});

  always_comb begin
    case (ctrl_i.quad)
      QUAD_0: begin
        sin_v = a_s;
        cos_v = b_s;
      end
      QUAD_1: begin
        sin_v = b_s;
        cos_v = -a_s;
      end
      QUAD_2: begin
        sin_v = -a_s;
        cos_v = -b_s;
      end
      QUAD_3: begin
        sin_v = -b_s;
        cos_v = a_s;
      end
      default: begin
        sin_v = a_s;
        cos_v = b_s;
      end
    endcase
  end

  assign p_ic = s_i_i * cos_v;
  assign p_qs = s_q_i * sin_v;
  assign p_is = s_i_i * sin_v;
  assign p_qc = s_q_i * cos_v;

  assign acc_i = ACC_W'(p_ic) - ACC_W'(p_qs) + ROUND;
  assign acc_q = ACC_W'(p_is) + ACC_W'(p_qc) + ROUND;
  assign sh_i  = acc_i >>> (SAMPLE_BITS - 1);
  assign sh_q  = acc_q >>> (SAMPLE_BITS - 1);

  always_comb begin
    if (sh_i > SAT_HI) begin
      sat_i = SAMPLE_BITS'(SAT_HI);
    end else if (sh_i < SAT_LO) begin
      sat_i = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_i = SAMPLE_BITS'(sh_i);
    end
    if (sh_q > SAT_HI) begin
      sat_q = SAMPLE_BITS'(SAT_HI);
    end else if (sh_q < SAT_LO) begin
      sat_q = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_q = SAMPLE_BITS'(sh_q);
    end
  end

  assign r_i_o = ctrl_i.bypass ? s_i_i : sat_i;
  assign r_q_o = ctrl_i.bypass ? s_q_i : sat_q;

endmodule

// File: src/ncomix_checker.sv
// Port-level checks on nco_complex_mixer_core, bound to the top level.
// Depends on ncomix_pkg and nco_complex_mixer_core_defines.svh.
`include "nco_complex_mixer_core_defines.svh"

module ncomix_props (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_ready_i,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input ncomix_pkg::sample_t                   out_i_i,
  input ncomix_pkg::sample_t                   out_q_i,
  input logic                                  psel_i,
  input logic                                  penable_i,
  input logic                                  pwrite_i,
  input logic [ncomix_pkg::APB_ADDR_BITS-1:0]  paddr_i,
  input logic [ncomix_pkg::CFG_DATA_BITS-1:0]  pwdata_i,
  input logic [ncomix_pkg::CFG_DATA_BITS-1:0]  prdata_i
);
  import ncomix_pkg::*;

  logic inc_sel;
  logic inc_write;
  logic out_stall;

  assign inc_sel   = (paddr_i == ADDR_PHASE_INC);
  assign inc_write = psel_i && penable_i && pwrite_i && inc_sel;
  assign out_stall = out_valid_i && !out_ready_i;

  `NCM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable({out_i_i, out_q_i}))
  `NCM_ASSERT_IMP(a_ready_follows, clk_i, rst_ni, out_ready_i, in_ready_i)
  `NCM_ASSERT_IMP(a_rise_after_ready, clk_i, rst_ni, $rose(out_valid_i), $past(in_ready_i))
  `NCM_ASSERT_NXT(a_inc_readback, clk_i, rst_ni, inc_write, !inc_sel || (prdata_i == $past(pwdata_i)))

endmodule

bind nco_complex_mixer_core ncomix_props u_ncomix_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (mixed_o.valid),
  .out_ready_i (mixed_o.ready),
  .out_i_i     (mixed_o.out_i),
  .out_q_i     (mixed_o.out_q),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
